// ----- sv/smsp_pkg.sv -----
// Package for the server message stream parser: phases, codes and event type.
`default_nettype none

package smsp_pkg;

  // Top-level opcodes
  localparam logic [15:0] OP_NOTIFY = 16'd9;
  localparam logic [15:0] OP_ACK    = 16'd10;
  localparam logic [15:0] OP_ERROR  = 16'd11;

  // Ack and error sub-opcodes
  localparam logic [15:0] SUB_LOGOUT  = 16'd3;
  localparam logic [15:0] SUB_NAMES_A = 16'd4;
  localparam logic [15:0] SUB_NAMES_B = 16'd7;
  localparam logic [15:0] SUB_STATS   = 16'd8;
  localparam logic [15:0] ERR_RELEASE = 16'd3;

  // Notification type byte that marks a PM ('0')
  localparam logic [7:0] CHAR_ZERO = 8'd48;

  // Text slots
  localparam logic [1:0] SLOT_USER    = 2'd0;
  localparam logic [1:0] SLOT_CONTENT = 2'd1;
  localparam logic [1:0] SLOT_NAME    = 2'd2;

  // Number of stats in an ack 8, minus one
  localparam logic [1:0] STAT_LAST = 2'd2;

  // Event kinds
  localparam logic [2:0] EV_NOTIFY   = 3'd0;
  localparam logic [2:0] EV_CHAR     = 3'd1;
  localparam logic [2:0] EV_TEXT_END = 3'd2;
  localparam logic [2:0] EV_ACK      = 3'd3;
  localparam logic [2:0] EV_COUNT    = 3'd4;
  localparam logic [2:0] EV_STAT     = 3'd5;
  localparam logic [2:0] EV_ERROR    = 3'd6;

  // Parser phase
  typedef enum logic [3:0] {
    PH_OP_HI   = 4'd0,
    PH_OP_LO   = 4'd1,
    PH_N_TYPE  = 4'd2,
    PH_N_TEXT  = 4'd3,
    PH_SUB_HI  = 4'd4,
    PH_SUB_LO  = 4'd5,
    PH_CNT_HI  = 4'd6,
    PH_CNT_LO  = 4'd7,
    PH_NAME    = 4'd8,
    PH_STAT_HI = 4'd9,
    PH_STAT_LO = 4'd10
  } phase_t;

  // One result word
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] value;
    logic [1:0]  text_slot;
    logic        message_done;
    logic        logout_ack;
    logic        release_keyboard;
  } evt_t;

endpackage

`default_nettype wire

// ----- sv/smsp_if.sv -----
// Channel interfaces for the parser: input byte channel and event channel.
`default_nettype none

interface smsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface smsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [15:0] value;
  logic [1:0]  text_slot;
  logic        message_done;
  logic        logout_ack;
  logic        release_keyboard;

  modport source (output valid, output event_kind, output value, output text_slot,
                  output message_done, output logout_ack, output release_keyboard,
                  input ready);
  modport sink   (input valid, input event_kind, input value, input text_slot,
                  input message_done, input logout_ack, input release_keyboard,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/smsp_core.sv -----
// Parser state machine: per-byte state update and event decode.
`default_nettype none

module smsp_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  output logic             evt_valid,
  output smsp_pkg::evt_t   evt
);
  import smsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        sub_err_r, sub_err_nxt;
  logic [14:0] names_r, names_nxt;
  logic        str_r, str_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        halt_r, halt_nxt;
  logic [15:0] word;
  logic [14:0] cnt;
  logic [14:0] names_dec;

  assign word      = {hold_r, in_byte};
  assign cnt       = word[15] ? 15'd0 : word[14:0];
  assign names_dec = (names_r != 15'd0) ? names_r - 15'd1 : names_r;

  // Next state and event for the current byte
  always_comb begin
    phase_nxt   = phase_r;
    hold_nxt    = hold_r;
    sub_err_nxt = sub_err_r;
    names_nxt   = names_r;
    str_nxt     = str_r;
    stat_nxt    = stat_r;
    halt_nxt    = halt_r;
    evt_valid   = 1'b0;
    evt         = '0;
    if (!halt_r) begin
      unique case (phase_r)
        PH_OP_HI: begin
          hold_nxt  = in_byte;
          phase_nxt = PH_OP_LO;
        end
        PH_SUB_HI: begin
          hold_nxt  = in_byte;
          phase_nxt = PH_SUB_LO;
        end
        PH_CNT_HI: begin
          hold_nxt  = in_byte;
          phase_nxt = PH_CNT_LO;
        end
        PH_STAT_HI: begin
          hold_nxt  = in_byte;
          phase_nxt = PH_STAT_LO;
        end
        PH_OP_LO: begin
          if (word == OP_NOTIFY) begin
            phase_nxt = PH_N_TYPE;
          end else if (word == OP_ACK) begin
            sub_err_nxt = 1'b0;
            phase_nxt   = PH_SUB_HI;
          end else if (word == OP_ERROR) begin
            sub_err_nxt = 1'b1;
            phase_nxt   = PH_SUB_HI;
          end else begin
            phase_nxt = PH_OP_HI;
          end
        end
        PH_N_TYPE: begin
          str_nxt          = 1'b0;
          phase_nxt        = PH_N_TEXT;
          evt_valid        = 1'b1;
          evt.event_kind   = EV_NOTIFY;
          evt.value        = {15'd0, in_byte == CHAR_ZERO};
        end
        PH_N_TEXT: begin
          evt_valid     = 1'b1;
          evt.text_slot = str_r ? SLOT_CONTENT : SLOT_USER;
          if (in_byte != 8'd0) begin
            evt.event_kind = EV_CHAR;
            evt.value      = {8'd0, in_byte};
          end else begin
            evt.event_kind   = EV_TEXT_END;
            evt.message_done = str_r;
            if (str_r) begin
              phase_nxt = PH_OP_HI;
            end else begin
              str_nxt = 1'b1;
            end
          end
        end
        PH_SUB_LO: begin
          evt_valid = 1'b1;
          evt.value = word;
          if (sub_err_r) begin
            phase_nxt            = PH_OP_HI;
            evt.event_kind       = EV_ERROR;
            evt.message_done     = 1'b1;
            evt.release_keyboard = (word == ERR_RELEASE);
          end else begin
            evt.event_kind = EV_ACK;
            if (word == SUB_LOGOUT) begin
              halt_nxt         = 1'b1;
              phase_nxt        = PH_OP_HI;
              evt.message_done = 1'b1;
              evt.logout_ack   = 1'b1;
            end else if (word == SUB_NAMES_A || word == SUB_NAMES_B) begin
              phase_nxt = PH_CNT_HI;
            end else if (word == SUB_STATS) begin
              stat_nxt  = 2'd0;
              phase_nxt = PH_STAT_HI;
            end else begin
              phase_nxt        = PH_OP_HI;
              evt.message_done = 1'b1;
            end
          end
        end
        PH_CNT_LO: begin
          names_nxt        = cnt;
          phase_nxt        = (cnt == 15'd0) ? PH_OP_HI : PH_NAME;
          evt_valid        = 1'b1;
          evt.event_kind   = EV_COUNT;
          evt.value        = word;
          evt.message_done = (cnt == 15'd0);
        end
        PH_NAME: begin
          evt_valid     = 1'b1;
          evt.text_slot = SLOT_NAME;
          if (in_byte != 8'd0) begin
            evt.event_kind = EV_CHAR;
            evt.value      = {8'd0, in_byte};
          end else begin
            names_nxt        = names_dec;
            evt.event_kind   = EV_TEXT_END;
            evt.message_done = (names_dec == 15'd0);
            if (names_dec == 15'd0) begin
              phase_nxt = PH_OP_HI;
            end
          end
        end
        PH_STAT_LO: begin
          evt_valid        = 1'b1;
          evt.event_kind   = EV_STAT;
          evt.value        = word;
          evt.message_done = (stat_r >= STAT_LAST);
          if (stat_r >= STAT_LAST) begin
            phase_nxt = PH_OP_HI;
          end else begin
            stat_nxt  = stat_r + 2'd1;
            phase_nxt = PH_STAT_HI;
          end
        end
        default: begin
          phase_nxt = PH_OP_HI;
        end
      endcase
    end
  end

  // State registers, updated per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OP_HI;
      sub_err_r <= 1'b0;
      names_r   <= '0;
      str_r     <= 1'b0;
      stat_r    <= '0;
      halt_r    <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      sub_err_r <= sub_err_nxt;
      names_r   <= names_nxt;
      str_r     <= str_nxt;
      stat_r    <= stat_nxt;
      halt_r    <= halt_nxt;
    end
  end

  // High byte of a 16-bit word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (accept) begin
      hold_r <= hold_nxt;
    end
  end

  // Once halted, stay halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("parser left halted state");

  // No event while halted
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !evt_valid) else $error("event produced while halted");

  // Name phase is only entered with names outstanding
  a_name_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_CNT_LO && phase_nxt == PH_NAME) |=> names_r != 15'd0)
    else $error("name phase entered with zero count");

endmodule

`default_nettype wire

// ----- sv/smsp_obuf.sv -----
// Two-entry output register: result register plus skid stage.
`default_nettype none

module smsp_obuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire smsp_pkg::evt_t push_evt,
  output logic                push_ready,
  smsp_out_if.source          out_ch
);
  import smsp_pkg::*;

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  evt_t main_r, main_nxt;
  evt_t skid_r, skid_nxt;
  logic pop;

  assign pop        = main_v_r && out_ch.ready;
  assign push_ready = !skid_v_r;

  // Refill main from skid first, else from the incoming word
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_evt;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid            = main_v_r;
  assign out_ch.event_kind       = main_r.event_kind;
  assign out_ch.value            = main_r.value;
  assign out_ch.text_slot        = main_r.text_slot;
  assign out_ch.message_done     = main_r.message_done;
  assign out_ch.logout_ack       = main_r.logout_ack;
  assign out_ch.release_keyboard = main_r.release_keyboard;

  // Skid only holds a word behind a full result register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r) else $error("skid full with result register empty");

  // Never pushed into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r) else $error("push into full buffer");

  // A word arriving at a stalled result register lands in the skid stage
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (push && main_v_r && !out_ch.ready) |=> skid_v_r)
    else $error("word lost during stall");

endmodule

`default_nettype wire

// ----- sv/server_message_stream_parser.sv -----
// Top level of the server message stream parser.
// The parser takes one byte of the server stream per cycle and emits at most one
// event word per byte; bytes that only build an opcode or the high half of a
// 16-bit field give no event. A byte is taken in every cycle while the output
// side keeps up: the state update is one small case decode between the state
// registers and a two-entry output buffer, so the event of an accepted byte is
// registered in the output buffer before it reaches out_ch, and input ready drops
// only when both output entries are full. After a logout ack the parser keeps
// accepting bytes but ignores them until reset.
`default_nettype none

module server_message_stream_parser (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smsp_in_if.sink     in_ch,
  smsp_out_if.source  out_ch
);
  import smsp_pkg::*;

  logic accept;
  logic evt_valid;
  evt_t evt;
  logic buf_ready;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;

  // Byte decode and parser state
  smsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_ch.in_byte),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  // Result register and skid stage
  smsp_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && evt_valid),
    .push_evt   (evt),
    .push_ready (buf_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- bench/tb_server_message_stream_parser.sv -----
// Testbench for the server message stream parser: byte driver, event predictor and checker.
`default_nettype none

module tb_server_message_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import smsp_pkg::*;

  typedef logic [7:0] bytes_t [$];

  logic clk;
  logic rst_n;

  smsp_in_if  in_ch ();
  smsp_out_if out_ch ();

  server_message_stream_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Idle rates, in percent, for the byte sender and the event receiver
  int send_idle_pct;
  int recv_idle_pct;

  // Bookkeeping
  int mismatches;
  int bytes_sent;
  int events_checked;
  int kind_seen [8];

  // Events predicted but not yet seen on out_ch
  evt_t pending_events [$];

  // Predictor state
  phase_t      pr_phase;
  logic [7:0]  pr_hold;
  logic        pr_sub_is_error;
  logic [14:0] pr_names_left;
  logic [1:0]  pr_slot;
  logic [1:0]  pr_stat_idx;
  logic        pr_halted;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void push_event(logic [2:0] kind, logic [15:0] val, logic [1:0] slot,
                                     logic done, logic logout, logic release_kb);
    evt_t e;
    e.event_kind       = kind;
    e.value            = val;
    e.text_slot        = slot;
    e.message_done     = done;
    e.logout_ack       = logout;
    e.release_keyboard = release_kb;
    pending_events.push_back(e);
  endfunction

  // Advance the parser model by one accepted byte and queue any event it causes
  function automatic void predict_byte(logic [7:0] b);
    logic [15:0] word;
    logic        done;
    word = {pr_hold, b};
    if (pr_halted) return;
    case (pr_phase)
      PH_OP_HI, PH_SUB_HI, PH_CNT_HI, PH_STAT_HI: begin
        pr_hold  = b;
        pr_phase = phase_t'(pr_phase + 4'd1);
      end
      PH_OP_LO: begin
        if (word == OP_NOTIFY) begin
          pr_phase = PH_N_TYPE;
        end else if (word == OP_ACK) begin
          pr_sub_is_error = 1'b0;
          pr_phase        = PH_SUB_HI;
        end else if (word == OP_ERROR) begin
          pr_sub_is_error = 1'b1;
          pr_phase        = PH_SUB_HI;
        end else begin
          pr_phase = PH_OP_HI;
        end
      end
      PH_N_TYPE: begin
        pr_slot  = SLOT_USER;
        pr_phase = PH_N_TEXT;
        push_event(EV_NOTIFY, {15'd0, b == CHAR_ZERO}, SLOT_USER, 1'b0, 1'b0, 1'b0);
      end
      PH_N_TEXT: begin
        if (b != 8'd0) begin
          push_event(EV_CHAR, {8'd0, b}, pr_slot, 1'b0, 1'b0, 1'b0);
        end else begin
          done = (pr_slot == SLOT_CONTENT);
          push_event(EV_TEXT_END, 16'd0, pr_slot, done, 1'b0, 1'b0);
          if (done) pr_phase = PH_OP_HI;
          else pr_slot = SLOT_CONTENT;
        end
      end
      PH_SUB_LO: begin
        if (pr_sub_is_error) begin
          pr_phase = PH_OP_HI;
          push_event(EV_ERROR, word, 2'd0, 1'b1, 1'b0, word == ERR_RELEASE);
        end else if (word == SUB_LOGOUT) begin
          pr_halted = 1'b1;
          pr_phase  = PH_OP_HI;
          push_event(EV_ACK, word, 2'd0, 1'b1, 1'b1, 1'b0);
        end else if (word == SUB_NAMES_A || word == SUB_NAMES_B) begin
          pr_phase = PH_CNT_HI;
          push_event(EV_ACK, word, 2'd0, 1'b0, 1'b0, 1'b0);
        end else if (word == SUB_STATS) begin
          pr_stat_idx = 2'd0;
          pr_phase    = PH_STAT_HI;
          push_event(EV_ACK, word, 2'd0, 1'b0, 1'b0, 1'b0);
        end else begin
          pr_phase = PH_OP_HI;
          push_event(EV_ACK, word, 2'd0, 1'b1, 1'b0, 1'b0);
        end
      end
      PH_CNT_LO: begin
        // a count with the top bit set means no names
        pr_names_left = word[15] ? 15'd0 : word[14:0];
        done          = (pr_names_left == 15'd0);
        pr_phase      = done ? PH_OP_HI : PH_NAME;
        push_event(EV_COUNT, word, 2'd0, done, 1'b0, 1'b0);
      end
      PH_NAME: begin
        if (b != 8'd0) begin
          push_event(EV_CHAR, {8'd0, b}, SLOT_NAME, 1'b0, 1'b0, 1'b0);
        end else begin
          if (pr_names_left != 15'd0) pr_names_left = pr_names_left - 15'd1;
          done = (pr_names_left == 15'd0);
          if (done) pr_phase = PH_OP_HI;
          push_event(EV_TEXT_END, 16'd0, SLOT_NAME, done, 1'b0, 1'b0);
        end
      end
      PH_STAT_LO: begin
        done = (pr_stat_idx >= STAT_LAST);
        if (done) begin
          pr_phase = PH_OP_HI;
        end else begin
          pr_stat_idx = pr_stat_idx + 2'd1;
          pr_phase    = PH_STAT_HI;
        end
        push_event(EV_STAT, word, 2'd0, done, 1'b0, 1'b0);
      end
      default: pr_phase = PH_OP_HI;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Compare every accepted event word with the oldest prediction
  always @(posedge clk) begin
    evt_t got;
    evt_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.event_kind, out_ch.value, out_ch.text_slot, out_ch.message_done,
             out_ch.logout_ack, out_ch.release_keyboard};
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event: expected none, got %h", $time, got);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
        check_field("value", want.value, got.value);
        check_field("text_slot", 16'(want.text_slot), 16'(got.text_slot));
        check_field("message_done", 16'(want.message_done), 16'(got.message_done));
        check_field("logout_ack", 16'(want.logout_ack), 16'(got.logout_ack));
        check_field("release_keyboard", 16'(want.release_keyboard),
                    16'(got.release_keyboard));
        events_checked++;
        kind_seen[got.event_kind]++;
      end
    end
  end

  // Send one byte; entered and left on a falling edge. With keep_alive set, a byte
  // that would complete a logout ack is altered so the parser keeps running.
  task automatic send_byte(input logic [7:0] b, input bit keep_alive);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    if (keep_alive && !pr_halted && pr_phase == PH_SUB_LO && !pr_sub_is_error &&
        {pr_hold, b} == SUB_LOGOUT)
      b = b ^ 8'h01;
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input bytes_t m, input bit keep_alive);
    foreach (m[i]) send_byte(m[i], keep_alive);
  endtask

  function automatic void push_word(ref bytes_t m, input logic [15:0] w);
    m.push_back(w[15:8]);
    m.push_back(w[7:0]);
  endfunction

  // Random nonzero characters and the terminating zero
  function automatic void push_text(ref bytes_t m, input int len);
    repeat (len) m.push_back(8'($urandom_range(255, 1)));
    m.push_back(8'd0);
  endfunction

  // One well-formed message with random content
  function automatic bytes_t random_message();
    bytes_t      m;
    int          pick;
    logic [15:0] w;
    pick = $urandom_range(99);
    if (pick < 25) begin
      push_word(m, OP_NOTIFY);
      m.push_back(($urandom_range(3) == 0) ? CHAR_ZERO : 8'($urandom_range(255)));
      push_text(m, $urandom_range(6));
      push_text(m, $urandom_range(6));
    end else if (pick < 42) begin
      push_word(m, OP_ACK);
      push_word(m, $urandom_range(1) ? SUB_NAMES_A : SUB_NAMES_B);
      case ($urandom_range(7))
        0:       w = {1'b1, 15'($urandom)};
        1:       w = 16'($urandom_range(40));
        default: w = 16'($urandom_range(4));
      endcase
      push_word(m, w);
      if (!w[15]) repeat (w) push_text(m, $urandom_range(3));
    end else if (pick < 57) begin
      push_word(m, OP_ACK);
      push_word(m, SUB_STATS);
      repeat (3) push_word(m, 16'($urandom));
    end else if (pick < 67) begin
      do w = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom);
      while (w inside {SUB_LOGOUT, SUB_NAMES_A, SUB_NAMES_B, SUB_STATS});
      push_word(m, OP_ACK);
      push_word(m, w);
    end else if (pick < 87) begin
      case ($urandom_range(3))
        0:       w = ERR_RELEASE;
        1:       w = 16'($urandom_range(15));
        default: w = 16'($urandom);
      endcase
      push_word(m, OP_ERROR);
      push_word(m, w);
    end else begin
      do w = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom);
      while (w inside {OP_NOTIFY, OP_ACK, OP_ERROR});
      push_word(m, w);
    end
    return m;
  endfunction

  // Feed zeros until the parser waits for an opcode again
  task automatic flush_to_opcode();
    while (pr_phase != PH_OP_HI && !pr_halted) send_byte(8'd0, 1'b1);
  endtask

  task automatic test_notifications();
    bytes_t m;
    // PM with text at the character extremes in both strings
    push_word(m, OP_NOTIFY);
    m.push_back(CHAR_ZERO);
    m.push_back(8'h01); m.push_back(8'hff); m.push_back(8'd0);
    m.push_back(8'h7f); m.push_back(8'h80); m.push_back(8'd0);
    // public, type byte zero, both strings empty
    push_word(m, OP_NOTIFY);
    m.push_back(8'h00); m.push_back(8'd0); m.push_back(8'd0);
    // public, type byte all ones
    push_word(m, OP_NOTIFY);
    m.push_back(8'hff); m.push_back(8'h55); m.push_back(8'd0); m.push_back(8'd0);
    send_bytes(m, 1'b0);
  endtask

  task automatic test_acks();
    bytes_t m;
    // plain acks end the message
    push_word(m, OP_ACK); push_word(m, 16'h0000);
    push_word(m, OP_ACK); push_word(m, 16'hffff);
    // stats at the extremes
    push_word(m, OP_ACK); push_word(m, SUB_STATS);
    push_word(m, 16'h0000); push_word(m, 16'hffff); push_word(m, 16'h8001);
    // name lists
    push_word(m, OP_ACK); push_word(m, SUB_NAMES_A); push_word(m, 16'd2);
    m.push_back(8'h41); m.push_back(8'd0); m.push_back(8'd0);
    push_word(m, OP_ACK); push_word(m, SUB_NAMES_B); push_word(m, 16'd1);
    m.push_back(8'hfe); m.push_back(8'd0);
    send_bytes(m, 1'b0);
  endtask

  task automatic test_counts();
    bytes_t m;
    // zero count and counts with the top bit set carry no names
    push_word(m, OP_ACK); push_word(m, SUB_NAMES_A); push_word(m, 16'h0000);
    push_word(m, OP_ACK); push_word(m, SUB_NAMES_B); push_word(m, 16'h8000);
    push_word(m, OP_ACK); push_word(m, SUB_NAMES_A); push_word(m, 16'hffff);
    send_bytes(m, 1'b0);
  endtask

  task automatic test_errors();
    bytes_t m;
    push_word(m, OP_ERROR); push_word(m, ERR_RELEASE);
    push_word(m, OP_ERROR); push_word(m, 16'h0000);
    push_word(m, OP_ERROR); push_word(m, 16'hffff);
    push_word(m, OP_ERROR); push_word(m, 16'h0103);
    send_bytes(m, 1'b0);
  endtask

  task automatic test_unknown_opcodes();
    bytes_t m;
    // skipped opcodes, then an ack to show the parser is back in step
    push_word(m, 16'h0000);
    push_word(m, 16'h0008);
    push_word(m, 16'h000c);
    push_word(m, 16'hff09);
    push_word(m, 16'h010a);
    push_word(m, OP_ACK); push_word(m, 16'h0001);
    send_bytes(m, 1'b0);
  endtask

  task automatic test_random_stream(input int n_bytes, input int s_idle, input int r_idle);
    bytes_t m;
    int     start;
    int     pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        // raw noise taken as opcodes and whatever follows
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)), 1'b1);
      end else begin
        m = random_message();
        // some messages are cut short
        if (pick < 15) m = m[0:$urandom_range(m.size() - 2)];
        send_bytes(m, 1'b1);
      end
      flush_to_opcode();
    end
  endtask

  task automatic test_logout();
    bytes_t m;
    push_word(m, OP_ACK); push_word(m, SUB_LOGOUT);
    // everything after the logout ack is ignored
    push_word(m, OP_ERROR); push_word(m, ERR_RELEASE);
    push_word(m, OP_NOTIFY); m.push_back(CHAR_ZERO); m.push_back(8'd0); m.push_back(8'd0);
    repeat (16) m.push_back(8'($urandom_range(255)));
    send_bytes(m, 1'b0);
  endtask

  initial begin
    int waited;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 86;
    mismatches = 0;
    bytes_sent = 0;
    events_checked = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    pr_phase = PH_OP_HI;
    pr_hold = 8'd0;
    pr_sub_is_error = 1'b0;
    pr_names_left = 15'd0;
    pr_slot = 2'd0;
    pr_stat_idx = 2'd0;
    pr_halted = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_notifications();
    test_acks();
    test_counts();
    test_errors();
    test_unknown_opcodes();
    test_random_stream(336, 18, 86);
    test_random_stream(336, 86, 18);
    test_random_stream(336, 0, 0);
    test_logout();
    in_ch.valid = 1'b0;

    // drain outstanding events, then allow for the output buffer
    waited = 0;
    while (pending_events.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_events.size() != 0) begin
      mismatches++;
      $display("%0t: %0d predicted events never arrived", $time, pending_events.size());
    end

    $display("summary: %0d bytes sent, %0d events checked, %0d mismatches",
             bytes_sent, events_checked, mismatches);
    $display("summary: notify %0d char %0d end %0d ack %0d count %0d stat %0d error %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
